// File: design/mapcs_pkg.sv
// ----------------------------------------------------------------------------
// mapcs_pkg
// Shared types and constants for the max-abs pivot row/column swap core.
// ----------------------------------------------------------------------------
package mapcs_pkg;

   // Register map, indexed by csr_paddr[3:2].
   localparam int          CSR_ADDR_W        = 4;
   localparam logic [1:0]  REG_ROW_COUNT     = 2'd0;
   localparam logic [1:0]  REG_COLUMN_COUNT  = 2'd1;
   localparam logic [1:0]  REG_PIVOT_TARGET  = 2'd2;

   localparam logic [3:0]  ROW_COUNT_RESET    = 4'd8;
   localparam logic [3:0]  COLUMN_COUNT_RESET = 4'd8;
   localparam logic [2:0]  PIVOT_TARGET_RESET = 3'd0;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   // Jobs that fit between the loader and the emitter.
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [3:0] row_count;
      logic [3:0] column_count;
      logic [2:0] pivot_target;
   } cfg_type;

   typedef enum logic {
      BK_IDLE,
      BK_RUN
   } back_state_type;

endpackage

// File: design/mapcs_queue.sv
// ----------------------------------------------------------------------------
// mapcs_queue
// Two-entry job queue between the loader and the emitter.
// ----------------------------------------------------------------------------
module mapcs_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] head_data
);

   logic [WIDTH-1:0] slot_ff [mapcs_pkg::QUEUE_DEPTH];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign full      = (count_ff == 2'(mapcs_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != 2'd0);
   assign head_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: design/mapcs_front.sv
// ----------------------------------------------------------------------------
// mapcs_front
// Matrix loader: writes elements into the store, tracks the pivot and queues
// one job per completed matrix.
// ----------------------------------------------------------------------------
module mapcs_front #(
   parameter int MAX_ROWS      = 8,
   parameter int MAX_COLS      = 8,
   parameter int ELEMENT_WIDTH = 32,
   parameter int ROW_W         = 3,
   parameter int COL_W         = 3,
   parameter int ADDR_W        = 7,
   parameter int JOB_W         = 52
) (
   input  logic                     clock,
   input  logic                     reset,
   input  mapcs_pkg::cfg_type       cfg,
   input  logic                     cfg_restart,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [ELEMENT_WIDTH-1:0] req_element,
   output logic                     mem_we,
   output logic [ADDR_W-1:0]        mem_waddr,
   output logic [ELEMENT_WIDTH-1:0] mem_wdata,
   output logic                     job_push,
   output logic [JOB_W-1:0]         job_data,
   input  logic                     job_full,
   input  logic                     job_done
);

   localparam int DEPTH = MAX_ROWS * MAX_COLS;

   typedef struct packed {
      logic                     bank;
      logic                     err;
      logic [ELEMENT_WIDTH-1:0] value;
      logic [ROW_W-1:0]         prow;
      logic [COL_W-1:0]         pcol;
      logic [ROW_W-1:0]         row_last;
      logic [COL_W-1:0]         col_last;
      logic [ROW_W-1:0]         k_row;
      logic [COL_W-1:0]         k_col;
   } job_type;

   logic [ROW_W-1:0]         row_ff, row_in;
   logic [COL_W-1:0]         col_ff, col_in;
   logic [ELEMENT_WIDTH:0]   best_mag_ff, best_mag_in;
   logic [ELEMENT_WIDTH-1:0] best_val_ff, best_val_in;
   logic [ROW_W-1:0]         best_row_ff, best_row_in;
   logic [COL_W-1:0]         best_col_ff, best_col_in;
   logic                     bank_ff, bank_in;
   logic [1:0]               jobs_ff, jobs_in;

   logic [7:0]               row_cnt_ext, col_cnt_ext;
   logic [ROW_W-1:0]         row_last;
   logic [COL_W-1:0]         col_last;
   logic                     accept, is_last, upd;
   logic [ELEMENT_WIDTH:0]   elem_ext, mag;
   logic [ELEMENT_WIDTH-1:0] sel_val;
   logic [ROW_W-1:0]         sel_row;
   logic [COL_W-1:0]         sel_col;
   job_type                  job;

   // Sizes clamped to 1..MAX and kept as the index of the last row/column.
   always_comb begin
      row_cnt_ext = 8'(cfg.row_count);
      col_cnt_ext = 8'(cfg.column_count);
      if (row_cnt_ext == 8'd0) begin
         row_last = '0;
      end else if (row_cnt_ext > 8'(MAX_ROWS)) begin
         row_last = ROW_W'(MAX_ROWS - 1);
      end else begin
         row_last = ROW_W'(row_cnt_ext - 8'd1);
      end
      if (col_cnt_ext == 8'd0) begin
         col_last = '0;
      end else if (col_cnt_ext > 8'(MAX_COLS)) begin
         col_last = COL_W'(MAX_COLS - 1);
      end else begin
         col_last = COL_W'(col_cnt_ext - 8'd1);
      end
   end

   // A bank may be loaded only while at most one other matrix is outstanding.
   assign req_ready = (jobs_ff < 2'd2) && !job_full;
   assign accept    = req_valid && req_ready;
   assign is_last   = (row_ff == row_last) && (col_ff == col_last);

   always_comb begin
      elem_ext = {req_element[ELEMENT_WIDTH-1], req_element};
      mag      = req_element[ELEMENT_WIDTH-1] ? (~elem_ext + 1'b1) : elem_ext;
      upd      = (mag > best_mag_ff);
      sel_val  = upd ? req_element : best_val_ff;
      sel_row  = upd ? row_ff : best_row_ff;
      sel_col  = upd ? col_ff : best_col_ff;
   end

   assign mem_we    = accept;
   assign mem_waddr = ADDR_W'(int'(bank_ff) * DEPTH + int'(row_ff) * MAX_COLS + int'(col_ff));
   assign mem_wdata = req_element;

   always_comb begin
      job.bank     = bank_ff;
      job.err      = (8'(cfg.pivot_target) > 8'(row_last)) ||
                     (8'(cfg.pivot_target) > 8'(col_last));
      job.value    = sel_val;
      job.prow     = sel_row;
      job.pcol     = sel_col;
      job.row_last = row_last;
      job.col_last = col_last;
      job.k_row    = ROW_W'(cfg.pivot_target);
      job.k_col    = COL_W'(cfg.pivot_target);
   end

   assign job_push = accept && is_last;
   assign job_data = job;

   always_comb begin
      row_in      = row_ff;
      col_in      = col_ff;
      best_mag_in = best_mag_ff;
      best_val_in = best_val_ff;
      best_row_in = best_row_ff;
      best_col_in = best_col_ff;
      bank_in     = bank_ff;
      jobs_in     = jobs_ff + 2'(job_push) - 2'(job_done);
      if (cfg_restart || job_push) begin
         row_in      = '0;
         col_in      = '0;
         best_mag_in = '0;
         best_val_in = '0;
         best_row_in = '0;
         best_col_in = '0;
         bank_in     = bank_ff ^ job_push;
      end else if (accept) begin
         best_mag_in = upd ? mag : best_mag_ff;
         best_val_in = sel_val;
         best_row_in = sel_row;
         best_col_in = sel_col;
         if (col_ff == col_last) begin
            col_in = '0;
            row_in = row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         best_mag_ff <= '0;
         best_val_ff <= '0;
         best_row_ff <= '0;
         best_col_ff <= '0;
         bank_ff     <= 1'b0;
         jobs_ff     <= 2'd0;
      end else begin
         row_ff      <= row_in;
         col_ff      <= col_in;
         best_mag_ff <= best_mag_in;
         best_val_ff <= best_val_in;
         best_row_ff <= best_row_in;
         best_col_ff <= best_col_in;
         bank_ff     <= bank_in;
         jobs_ff     <= jobs_in;
      end
   end

endmodule

// File: design/mapcs_back.sv
// ----------------------------------------------------------------------------
// mapcs_back
// Emitter: holds the two-bank matrix store and streams the permuted matrix
// (or one range error) of each queued job through a read stage and an output register.
// ----------------------------------------------------------------------------
module mapcs_back #(
   parameter int MAX_ROWS      = 8,
   parameter int MAX_COLS      = 8,
   parameter int ELEMENT_WIDTH = 32,
   parameter int ROW_W         = 3,
   parameter int COL_W         = 3,
   parameter int ADDR_W        = 7,
   parameter int JOB_W         = 52
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     mem_we,
   input  logic [ADDR_W-1:0]        mem_waddr,
   input  logic [ELEMENT_WIDTH-1:0] mem_wdata,
   input  logic                     job_valid,
   input  logic [JOB_W-1:0]         job_data,
   output logic                     job_pop,
   output logic                     job_done,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [ELEMENT_WIDTH-1:0] rsp_out_element,
   output logic [ROW_W-1:0]         rsp_out_row,
   output logic [COL_W-1:0]         rsp_out_col,
   output logic [ELEMENT_WIDTH-1:0] rsp_pivot_value,
   output logic [ROW_W-1:0]         rsp_pivot_row,
   output logic [COL_W-1:0]         rsp_pivot_col,
   output logic                     rsp_status,
   output logic                     rsp_last
);

   localparam int DEPTH = MAX_ROWS * MAX_COLS;

   typedef struct packed {
      logic                     bank;
      logic                     err;
      logic [ELEMENT_WIDTH-1:0] value;
      logic [ROW_W-1:0]         prow;
      logic [COL_W-1:0]         pcol;
      logic [ROW_W-1:0]         row_last;
      logic [COL_W-1:0]         col_last;
      logic [ROW_W-1:0]         k_row;
      logic [COL_W-1:0]         k_col;
   } job_type;

   logic [ELEMENT_WIDTH-1:0] store_mem [2 * DEPTH];

   mapcs_pkg::back_state_type state_ff, state_in;
   job_type                   job_ff;
   logic [ROW_W-1:0]          i_ff;
   logic [COL_W-1:0]          j_ff;

   // Read stage: metadata travels beside the registered store output.
   logic                      s1_valid_ff;
   logic                      s1_err_ff, s1_last_ff;
   logic [ROW_W-1:0]          s1_row_ff;
   logic [COL_W-1:0]          s1_col_ff;
   logic [ELEMENT_WIDTH-1:0]  rd_data_ff;

   logic                      rsp_valid_ff;
   logic                      issue_ok, issue, s1_adv, at_end;
   logic [ROW_W-1:0]          src_row;
   logic [COL_W-1:0]          src_col;
   logic [ADDR_W-1:0]         rd_addr;

   assign s1_adv   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign issue_ok = !s1_valid_ff || s1_adv;
   assign at_end   = (i_ff == job_ff.row_last) && (j_ff == job_ff.col_last);

   always_comb begin
      if (i_ff == job_ff.prow) begin
         src_row = job_ff.k_row;
      end else if (i_ff == job_ff.k_row) begin
         src_row = job_ff.prow;
      end else begin
         src_row = i_ff;
      end
      if (j_ff == job_ff.pcol) begin
         src_col = job_ff.k_col;
      end else if (j_ff == job_ff.k_col) begin
         src_col = job_ff.pcol;
      end else begin
         src_col = j_ff;
      end
      rd_addr = ADDR_W'(int'(job_ff.bank) * DEPTH + int'(src_row) * MAX_COLS
                        + int'(src_col));
   end

   // A new job is taken only once the read stage is empty or moving on, so the
   // previous job's pivot data is still in place for its last transaction.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mapcs_pkg::BK_IDLE: begin
            if (job_valid && issue_ok) begin
               state_in = mapcs_pkg::BK_RUN;
            end
         end
         mapcs_pkg::BK_RUN: begin
            if (issue_ok && (job_ff.err || at_end)) begin
               state_in = mapcs_pkg::BK_IDLE;
            end
         end
         default: state_in = mapcs_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      job_pop  = 1'b0;
      issue    = 1'b0;
      job_done = 1'b0;
      case (state_ff)
         mapcs_pkg::BK_IDLE: begin
            job_pop = job_valid && issue_ok;
         end
         mapcs_pkg::BK_RUN: begin
            issue    = issue_ok;
            job_done = issue_ok && (job_ff.err || at_end);
         end
         default: begin
            job_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      if (issue && !job_ff.err) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mapcs_pkg::BK_IDLE;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (issue) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         job_ff <= job_data;
         i_ff   <= '0;
         j_ff   <= '0;
      end else if (issue) begin
         if (j_ff == job_ff.col_last) begin
            j_ff <= '0;
            i_ff <= i_ff + 1'b1;
         end else begin
            j_ff <= j_ff + 1'b1;
         end
      end
      if (issue) begin
         s1_err_ff  <= job_ff.err;
         s1_last_ff <= job_ff.err || at_end;
         s1_row_ff  <= i_ff;
         s1_col_ff  <= j_ff;
      end
      // Output fields; pivot data comes from the running job, which stays
      // loaded until the last element has left the read stage.
      if (s1_adv) begin
         rsp_out_element <= s1_err_ff ? '0 : rd_data_ff;
         rsp_out_row     <= s1_err_ff ? '0 : s1_row_ff;
         rsp_out_col     <= s1_err_ff ? '0 : s1_col_ff;
         rsp_pivot_value <= s1_err_ff ? '0 : job_ff.value;
         rsp_pivot_row   <= s1_err_ff ? '0 : job_ff.prow;
         rsp_pivot_col   <= s1_err_ff ? '0 : job_ff.pcol;
         rsp_status      <= s1_err_ff ? mapcs_pkg::STATUS_RANGE : mapcs_pkg::STATUS_OK;
         rsp_last        <= s1_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: design/max_abs_pivot_row_col_swap_core.sv
// ----------------------------------------------------------------------------
// max_abs_pivot_row_col_swap_core
// Loads a matrix, finds the element of greatest magnitude, swaps its row and
// column onto diagonal index k and streams out the permuted matrix (or one range error).
//
//   channel  direction  handshake          payload
//   req      in         req_valid/ready    element
//   rsp      out        rsp_valid/ready    permuted element, indexes, pivot
//   csr      in/out     APB psel/penable   row_count, column_count, target
//
// One element is taken per cycle while loading. A finished matrix is emitted
// at one result per cycle; with the emitter idle, its first result passes the
// job queue, the job register, the read stage and the output register,
// while the next matrix loads into the other bank of the store. Loading stalls
// while two matrices are still outstanding, so emission sets the sustained rate.
// Reset is synchronous and clears control state only; the store is not
// cleared. Back-pressure on rsp stalls the emitter at once and the loader
// once two matrices are outstanding.
// ----------------------------------------------------------------------------
module max_abs_pivot_row_col_swap_core #(
   parameter int MAX_ROWS      = 8,
   parameter int MAX_COLS      = 8,
   parameter int ELEMENT_WIDTH = 32,
   localparam int ROW_W        = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
   localparam int COL_W        = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [ELEMENT_WIDTH-1:0]           req_element,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [ELEMENT_WIDTH-1:0]           rsp_out_element,
   output logic [ROW_W-1:0]                   rsp_out_row,
   output logic [COL_W-1:0]                   rsp_out_col,
   output logic [ELEMENT_WIDTH-1:0]           rsp_pivot_value,
   output logic [ROW_W-1:0]                   rsp_pivot_row,
   output logic [COL_W-1:0]                   rsp_pivot_col,
   output logic                               rsp_status,
   output logic                               rsp_last,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [mapcs_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);

   localparam int ADDR_W = $clog2(2 * MAX_ROWS * MAX_COLS);
   localparam int JOB_W  = 2 + ELEMENT_WIDTH + 3 * ROW_W + 3 * COL_W;

   mapcs_pkg::cfg_type cfg_ff, cfg_in;
   logic               csr_write, cfg_restart;
   logic [1:0]         reg_index;

   logic                     mem_we;
   logic [ADDR_W-1:0]        mem_waddr;
   logic [ELEMENT_WIDTH-1:0] mem_wdata;
   logic                     job_push, job_full, job_pop, job_valid, job_done;
   logic [JOB_W-1:0]         job_in_data, job_out_data;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign reg_index  = csr_paddr[3:2];

   always_comb begin
      cfg_in      = cfg_ff;
      cfg_restart = 1'b0;
      if (csr_write) begin
         case (reg_index)
            mapcs_pkg::REG_ROW_COUNT: begin
               cfg_in.row_count = csr_pwdata[3:0];
               cfg_restart      = 1'b1;
            end
            mapcs_pkg::REG_COLUMN_COUNT: begin
               cfg_in.column_count = csr_pwdata[3:0];
               cfg_restart         = 1'b1;
            end
            mapcs_pkg::REG_PIVOT_TARGET: begin
               cfg_in.pivot_target = csr_pwdata[2:0];
               cfg_restart         = 1'b1;
            end
            default: cfg_restart = 1'b0;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         mapcs_pkg::REG_ROW_COUNT:    csr_prdata = 32'(cfg_ff.row_count);
         mapcs_pkg::REG_COLUMN_COUNT: csr_prdata = 32'(cfg_ff.column_count);
         mapcs_pkg::REG_PIVOT_TARGET: csr_prdata = 32'(cfg_ff.pivot_target);
         default:                     csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row_count    <= mapcs_pkg::ROW_COUNT_RESET;
         cfg_ff.column_count <= mapcs_pkg::COLUMN_COUNT_RESET;
         cfg_ff.pivot_target <= mapcs_pkg::PIVOT_TARGET_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mapcs_front #(
      .MAX_ROWS      (MAX_ROWS),
      .MAX_COLS      (MAX_COLS),
      .ELEMENT_WIDTH (ELEMENT_WIDTH),
      .ROW_W         (ROW_W),
      .COL_W         (COL_W),
      .ADDR_W        (ADDR_W),
      .JOB_W         (JOB_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .cfg_restart (cfg_restart),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_element (req_element),
      .mem_we      (mem_we),
      .mem_waddr   (mem_waddr),
      .mem_wdata   (mem_wdata),
      .job_push    (job_push),
      .job_data    (job_in_data),
      .job_full    (job_full),
      .job_done    (job_done)
   );

   mapcs_queue #(
      .WIDTH (JOB_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in_data),
      .full      (job_full),
      .pop       (job_pop),
      .not_empty (job_valid),
      .head_data (job_out_data)
   );

   mapcs_back #(
      .MAX_ROWS      (MAX_ROWS),
      .MAX_COLS      (MAX_COLS),
      .ELEMENT_WIDTH (ELEMENT_WIDTH),
      .ROW_W         (ROW_W),
      .COL_W         (COL_W),
      .ADDR_W        (ADDR_W),
      .JOB_W         (JOB_W)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .mem_we          (mem_we),
      .mem_waddr       (mem_waddr),
      .mem_wdata       (mem_wdata),
      .job_valid       (job_valid),
      .job_data        (job_out_data),
      .job_pop         (job_pop),
      .job_done        (job_done),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_element (rsp_out_element),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_pivot_value (rsp_pivot_value),
      .rsp_pivot_row   (rsp_pivot_row),
      .rsp_pivot_col   (rsp_pivot_col),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last)
   );

endmodule

// File: tb/sv/max_abs_pivot_row_col_swap_core_test.sv
// ----------------------------------------------------------------------------
// max_abs_pivot_row_col_swap_core_test
// Self-checking bench for the max-abs pivot row/column swap core. Matrices
// are streamed in element by element under several register settings. A
// scoreboard tracks the pivot search and the swap in step with the block,
// and it compares every result transaction field by field, in order.
// ----------------------------------------------------------------------------
module max_abs_pivot_row_col_swap_core_test;

   localparam int          STORE_COLS    = 8;
   localparam int          SETTLE_CYCLES = 24;
   localparam int          STALL_LIMIT   = 3000;
   localparam int          RANDOM_ITEMS  = 440;
   localparam int          CALM_AFTER    = 370;
   localparam logic [1:0]  REG_UNMAPPED  = 2'd3;

   typedef struct packed {
      logic [31:0] element;
      logic [2:0]  row;
      logic [2:0]  col;
      logic [31:0] pivot_value;
      logic [2:0]  pivot_row;
      logic [2:0]  pivot_col;
      logic        status;
      logic        last;
   } swap_entry_type;

   class swap_scoreboard;
      mapcs_pkg::cfg_type cfg = '{mapcs_pkg::ROW_COUNT_RESET,
                                  mapcs_pkg::COLUMN_COUNT_RESET,
                                  mapcs_pkg::PIVOT_TARGET_RESET};
      logic [31:0]  store [64];
      int unsigned  load_count = 0;
      logic [32:0]  best_mag = '0;
      logic [31:0]  best_value = '0;
      logic [2:0]   best_row = '0;
      logic [2:0]   best_col = '0;
      swap_entry_type expected_entries [$];
      int           error_count = 0;
      int           entries_checked = 0;
      int           range_flags = 0;
      int           matrices_done = 0;
      int           elements_noted = 0;

      task report_mismatch(string msg);
         error_count++;
         $display("MISMATCH: %s", msg);
      endtask

      function void restart_load();
         load_count = 0;
         best_mag   = '0;
         best_value = '0;
         best_row   = '0;
         best_col   = '0;
      endfunction

      function int unsigned clamp_size(logic [3:0] v);
         if (v == 0) return 1;
         if (v > 8) return 8;
         return v;
      endfunction

      function void apply_write(logic [1:0] reg_index, logic [31:0] data);
         case (reg_index)
            mapcs_pkg::REG_ROW_COUNT:    cfg.row_count    = data[3:0];
            mapcs_pkg::REG_COLUMN_COUNT: cfg.column_count = data[3:0];
            mapcs_pkg::REG_PIVOT_TARGET: cfg.pivot_target = data[2:0];
            default:                     return;
         endcase
         restart_load();
      endfunction

      function logic [31:0] register_value(logic [1:0] reg_index);
         case (reg_index)
            mapcs_pkg::REG_ROW_COUNT:    return {28'd0, cfg.row_count};
            mapcs_pkg::REG_COLUMN_COUNT: return {28'd0, cfg.column_count};
            mapcs_pkg::REG_PIVOT_TARGET: return {29'd0, cfg.pivot_target};
            default:                     return '0;
         endcase
      endfunction

      function int pending();
         return expected_entries.size();
      endfunction

      // Loads one element and, on the last one of a matrix, queues the whole
      // permuted matrix (or the single range error).
      function void note_element(logic [31:0] elem);
         int unsigned rows, cols, r, c, k, i, j, sr, sc;
         logic [32:0] mag;
         swap_entry_type entry;
         rows = clamp_size(cfg.row_count);
         cols = clamp_size(cfg.column_count);
         elements_noted++;
         if (load_count >= rows * cols) load_count = 0;
         r = load_count / cols;
         c = load_count % cols;
         store[r * STORE_COLS + c] = elem;
         mag = elem[31] ? {1'b0, ~elem + 32'd1} : {1'b0, elem};
         if (mag > best_mag) begin
            best_mag   = mag;
            best_value = elem;
            best_row   = r[2:0];
            best_col   = c[2:0];
         end
         load_count++;
         if (load_count < rows * cols) return;
         matrices_done++;
         k = cfg.pivot_target;
         if (k >= rows || k >= cols) begin
            entry = '0;
            entry.status = mapcs_pkg::STATUS_RANGE;
            entry.last   = 1'b1;
            expected_entries.push_back(entry);
            restart_load();
            return;
         end
         for (i = 0; i < rows; i++) begin
            sr = (i == best_row) ? k : (i == k) ? best_row : i;
            for (j = 0; j < cols; j++) begin
               sc = (j == best_col) ? k : (j == k) ? best_col : j;
               entry.element     = store[sr * STORE_COLS + sc];
               entry.row         = i[2:0];
               entry.col         = j[2:0];
               entry.pivot_value = best_value;
               entry.pivot_row   = best_row;
               entry.pivot_col   = best_col;
               entry.status      = mapcs_pkg::STATUS_OK;
               entry.last        = (i == rows - 1) && (j == cols - 1);
               expected_entries.push_back(entry);
            end
         end
         restart_load();
      endfunction

      task check_entry(swap_entry_type got);
         swap_entry_type want;
         string diffs;
         if (expected_entries.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected: %h", got));
            return;
         end
         want = expected_entries.pop_front();
         entries_checked++;
         if (want.status == mapcs_pkg::STATUS_RANGE) range_flags++;
         diffs = "";
         if (got.element !== want.element)         diffs = {diffs, " out_element"};
         if (got.row !== want.row)                 diffs = {diffs, " out_row"};
         if (got.col !== want.col)                 diffs = {diffs, " out_col"};
         if (got.pivot_value !== want.pivot_value) diffs = {diffs, " pivot_value"};
         if (got.pivot_row !== want.pivot_row)     diffs = {diffs, " pivot_row"};
         if (got.pivot_col !== want.pivot_col)     diffs = {diffs, " pivot_col"};
         if (got.status !== want.status)           diffs = {diffs, " status"};
         if (got.last !== want.last)               diffs = {diffs, " last"};
         if (diffs != "")
            report_mismatch($sformatf("result %0d:%s wrong, got %h want %h",
                                      entries_checked, diffs, got, want));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_element;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_out_element;
   logic [2:0]  rsp_out_row;
   logic [2:0]  rsp_out_col;
   logic [31:0] rsp_pivot_value;
   logic [2:0]  rsp_pivot_row;
   logic [2:0]  rsp_pivot_col;
   logic        rsp_status;
   logic        rsp_last;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [mapcs_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   swap_scoreboard sb;
   bit             calm = 1'b0;
   int unsigned    quiet_cycles = 0;
   int unsigned    settings_used = 0;
   logic [31:0]    last_big = 32'h1234_5678;

   max_abs_pivot_row_col_swap_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_element     (req_element),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_element (rsp_out_element),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_pivot_value (rsp_pivot_value),
      .rsp_pivot_row   (rsp_pivot_row),
      .rsp_pivot_col   (rsp_pivot_col),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Every handshake is observed here, on the values that held before the edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            sb.apply_write(csr_paddr[3:2], csr_pwdata);
         if (req_valid && req_ready) sb.note_element(req_element);
         if (rsp_valid && rsp_ready)
            sb.check_entry({rsp_out_element, rsp_out_row, rsp_out_col, rsp_pivot_value,
                            rsp_pivot_row, rsp_pivot_col, rsp_status, rsp_last});
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("max_abs_pivot_row_col_swap_core_test: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // The receiver stalls in random bursts until the final stretch of the run.
   initial begin
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(posedge clock);
      end
   end

   task automatic csr_write(logic [1:0] reg_index, logic [3:0] value);
      logic [31:0] data;
      data = {28'd0, value};
      if ($urandom_range(0, 3) == 0) data[31:4] = $urandom;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_index, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic csr_check(logic [1:0] reg_index);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {reg_index, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== sb.register_value(reg_index))
         sb.report_mismatch($sformatf("register %0d reads %h, want %h", reg_index,
                                      csr_prdata, sb.register_value(reg_index)));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic configure(logic [3:0] rows, logic [3:0] cols, logic [2:0] target);
      csr_write(mapcs_pkg::REG_ROW_COUNT, rows);
      csr_write(mapcs_pkg::REG_COLUMN_COUNT, cols);
      csr_write(mapcs_pkg::REG_PIVOT_TARGET, {1'b0, target});
      csr_check(mapcs_pkg::REG_ROW_COUNT);
      csr_check(mapcs_pkg::REG_COLUMN_COUNT);
      csr_check(mapcs_pkg::REG_PIVOT_TARGET);
      settings_used++;
   endtask

   // Valid stays high across back-to-back transactions; it drops only for a gap.
   task automatic send_element(logic [31:0] value);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_element <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Waits until every queued result has come back and the block has gone quiet.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_element();
      logic [31:0] v;
      case ($urandom_range(0, 11))
         0:       v = 32'h8000_0000;
         1:       v = 32'h7FFF_FFFF;
         2:       v = 32'h8000_0001;
         3:       v = '0;
         4:       v = '1;
         5:       v = 32'd0 - last_big;
         6, 7:    v = 32'($urandom_range(0, 40)) - 32'd20;
         default: v = $urandom;
      endcase
      // Keeping the value lets a later element tie it in magnitude.
      if (v != 32'd0 - last_big) last_big = v;
      return v;
   endfunction

   function automatic logic [3:0] pick_size();
      case ($urandom_range(0, 9))
         6, 7:    return 4'($urandom_range(5, 8));
         8:       return 4'd0;
         9:       return 4'($urandom_range(9, 15));
         default: return 4'($urandom_range(1, 4));
      endcase
   endfunction

   initial begin
      logic [3:0]  rows, cols;
      logic [2:0]  target;
      int unsigned total, span, matrices, random_sent, m, e;
      bit          widest_done;
      sb = new;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_element <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_check(mapcs_pkg::REG_ROW_COUNT);
      csr_check(mapcs_pkg::REG_COLUMN_COUNT);
      csr_check(mapcs_pkg::REG_PIVOT_TARGET);

      // Single element: the most negative value is the pivot.
      configure(4'd1, 4'd1, 3'd0);
      send_element(32'h8000_0000);
      settle();

      // All zeros pick position 0,0, then row 0 and column 0 move to index 1.
      configure(4'd2, 4'd2, 3'd1);
      repeat (4) send_element(32'd0);
      settle();

      // Equal magnitudes: the earlier element stays the pivot.
      configure(4'd2, 4'd2, 3'd0);
      send_element(32'd5);
      send_element(32'h7FFF_FFFF);
      send_element(32'h8000_0001);
      send_element(-32'sd7);
      settle();

      // Target beyond the row count gives one range error.
      configure(4'd1, 4'd2, 3'd1);
      send_element(32'd3);
      send_element(-32'sd4);
      settle();

      // Zero rows clamp to one, fifteen columns clamp to the maximum.
      configure(4'd0, 4'd15, 3'd0);
      send_element(32'hFFFF_FFFF);
      send_element(32'd1);
      send_element(32'h8000_0000);
      send_element(32'h7FFF_FFFF);
      send_element(32'd0);
      send_element(32'h8000_0000);
      send_element(32'h1234_5678);
      send_element(32'hEDCB_A987);
      settle();

      // A write to an unused address leaves a partial load alone; a real
      // register write throws it away.
      configure(4'd2, 4'd1, 3'd0);
      send_element(32'd9);
      settle();
      csr_write(REG_UNMAPPED, 4'd5);
      send_element(-32'sd11);
      send_element(32'd2);
      settle();
      csr_write(mapcs_pkg::REG_PIVOT_TARGET, 4'd0);
      send_element(32'd6);
      send_element(-32'sd6);
      settle();

      random_sent = 0;
      widest_done = 1'b0;
      while (random_sent < RANDOM_ITEMS) begin
         if (!widest_done) begin
            rows = 4'd8;
            cols = 4'd8;
            target = 3'd7;
            widest_done = 1'b1;
         end else begin
            rows = pick_size();
            cols = pick_size();
            span = (sb.clamp_size(rows) < sb.clamp_size(cols)) ?
                   sb.clamp_size(rows) : sb.clamp_size(cols);
            if ($urandom_range(0, 4) == 0) target = 3'($urandom_range(0, 7));
            else target = 3'($urandom_range(0, span - 1));
         end
         configure(rows, cols, target);
         total = sb.clamp_size(rows) * sb.clamp_size(cols);
         matrices = (total >= 32) ? 1 : $urandom_range(1, 3);
         for (m = 0; m < matrices; m++) begin
            for (e = 0; e < total; e++) begin
               send_element(pick_element());
               random_sent++;
               if (random_sent >= CALM_AFTER) calm = 1'b1;
            end
         end
         // Now and then leave a matrix half loaded for the next write to discard.
         if (total > 1 && $urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, total - 1)) send_element(pick_element());
         end
         settle();
      end

      if (sb.pending() != 0)
         sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
      $display("Covered %0d matrices (%0d range errors) under %0d register settings.",
               sb.matrices_done, sb.range_flags, settings_used);
      $display("Loaded %0d elements and checked %0d result transactions.",
               sb.elements_noted, sb.entries_checked);
      if (sb.error_count == 0) begin
         $display("max_abs_pivot_row_col_swap_core_test: done, clean");
      end else begin
         $display("max_abs_pivot_row_col_swap_core_test: done, errors");
      end
      $finish;
   end

endmodule

// File: max_abs_pivot_row_col_swap_core.f
design/mapcs_pkg.sv
design/mapcs_queue.sv
design/mapcs_front.sv
design/mapcs_back.sv
design/max_abs_pivot_row_col_swap_core.sv
tb/sv/max_abs_pivot_row_col_swap_core_test.sv
